// ===== src/i128_pkg.sv =====
`default_nettype none
package i128_pkg;
   localparam int WORD_BITS_DEF = 128;
   localparam int OP_W = 4;
   localparam int SH_W = 8;
   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
      OP_SHL = 4'd5, OP_SAR = 4'd6, OP_AND = 4'd7, OP_OR = 4'd8, OP_CMP = 4'd9
   } op_type;
   // control carried down the divider row with each beat
   typedef struct packed {
      logic       valid;
      logic [3:0] op;
      logic       neg_q;
      logic       neg_r;
      logic       dz;
   } ctl_type;
endpackage
`default_nettype wire

// ===== src/i128_div_cell.sv =====
`default_nettype none
// one restoring division step; also carries a precomputed result alongside
module i128_div_cell #(
   parameter int W = i128_pkg::WORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               stall,
   input  wire i128_pkg::ctl_type  ctl_i,
   input  wire logic [W-1:0]       rem_i,
   input  wire logic [W-1:0]       num_i,
   input  wire logic [W-1:0]       den_i,
   input  wire logic [W-1:0]       res_i,
   output      i128_pkg::ctl_type  ctl_o,
   output      logic [W-1:0]       rem_o,
   output      logic [W-1:0]       num_o,
   output      logic [W-1:0]       den_o,
   output      logic [W-1:0]       res_o
);
   i128_pkg::ctl_type ctl_ff;
   logic [W-1:0] rem_ff, num_ff, den_ff, res_ff;
   logic [W:0]   sh, diff;
   logic [W-1:0] rem_in, num_in;

   // shift in next dividend bit, subtract if it fits; quotient bit enters num
   always_comb begin
      sh     = {rem_i, num_i[W-1]};
      diff   = sh - {1'b0, den_i};
      if (!diff[W]) begin
         rem_in = diff[W-1:0];
         num_in = {num_i[W-2:0], 1'b1};
      end else begin
         rem_in = sh[W-1:0];
         num_in = {num_i[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (!stall) begin
         ctl_ff <= ctl_i;
      end
      if (!stall) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_i;
         res_ff <= res_i;
      end
   end
   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign res_o = res_ff;
endmodule
`default_nettype wire

// ===== src/i128_front.sv =====
`default_nettype none
// operand fitting, simple ops, multiply and divider setup; one register stage
module i128_front #(
   parameter int W = i128_pkg::WORD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              stall,
   input  wire logic              in_valid,
   input  wire logic [3:0]        op,
   input  wire logic [127:0]      a_raw,
   input  wire logic [127:0]      b_raw,
   input  wire logic [7:0]        shift_amount,
   output      i128_pkg::ctl_type ctl_o,
   output      logic [W-1:0]      num_o,
   output      logic [W-1:0]      den_o,
   output      logic [W-1:0]      res_o
);
   logic [W-1:0] a, b, am, bm, res_in;
   logic [127:0] lo_a, lo_b;
   logic [W-1:0] part;
   logic an, bn, bz;
   logic [2*W-1:0] sar_ext;
   i128_pkg::ctl_type ctl_in;
   // multiply partial product registers (32x32 pieces summed in next stage)
   logic [63:0] pp_ff [16];
   logic [63:0] pp_in [16];
   logic [W-1:0] mul_sum;
   logic [3:0] op_ff;
   logic [W-1:0] num_ff, den_ff, res_ff;
   i128_pkg::ctl_type ctl_ff;

   always_comb begin
      a  = a_raw[W-1:0];
      b  = b_raw[W-1:0];
      an = a[W-1];
      bn = b[W-1];
      bz = (b == '0);
      am = an ? (~a + 1'b1) : a;
      bm = bn ? (~b + 1'b1) : b;
      sar_ext = {{W{an}}, a} >> ((shift_amount >= 8'(W)) ? W : int'(shift_amount));
      // sign-extended to 128 bits so partial products cover any width up to 128
      lo_a = 128'($signed(a));
      lo_b = 128'($signed(b));
      part = '0;
      res_in = '0;
      unique case (op)
         i128_pkg::OP_ADD: res_in = a + b;
         i128_pkg::OP_SUB: res_in = a - b;
         i128_pkg::OP_DIV: res_in = '1;
         i128_pkg::OP_REM: res_in = a;
         i128_pkg::OP_SHL: res_in = (shift_amount >= 8'(W)) ? '0 : (a << shift_amount);
         i128_pkg::OP_SAR: res_in = sar_ext[W-1:0];
         i128_pkg::OP_AND: res_in = a & b;
         i128_pkg::OP_OR:  res_in = a | b;
         i128_pkg::OP_CMP: begin
            res_in[0] = (a == b);
            res_in[1] = ($signed(a) < $signed(b));
            res_in[2] = ($signed(a) > $signed(b));
         end
         default: res_in = part;
      endcase
      ctl_in.valid = in_valid;
      ctl_in.op    = op;
      ctl_in.neg_q = an ^ bn;
      ctl_in.neg_r = an;
      ctl_in.dz    = bz && (op == i128_pkg::OP_DIV || op == i128_pkg::OP_REM);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_in[i*4+j] = {32'd0, lo_a[32*i +: 32]} * {32'd0, lo_b[32*j +: 32]};
         end
      end
   end

   always_comb begin
      mul_sum = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            mul_sum = mul_sum + W'({pp_ff[i*4+j], 256'd0} >> (256 - 32*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (!stall) begin
         ctl_ff <= ctl_in;
      end
      if (!stall) begin
         op_ff  <= op;
         num_ff <= (bz ? '0 : am);
         den_ff <= bm;
         res_ff <= res_in;
         for (int k = 0; k < 16; k++) pp_ff[k] <= pp_in[k];
      end
   end

   assign ctl_o = ctl_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign res_o = (op_ff == i128_pkg::OP_MUL) ? mul_sum : res_ff;
endmodule
`default_nettype wire

// ===== src/int128_alu_top.sv =====
`default_nettype none
// every op's req beat passes the front, WORD_BITS cell and output registers
// one beat per cycle unless stalled; divider is a row of WORD_BITS step cells
// the whole pipe stalls only while a finished rsp beat is not taken
// reset: synchronous, active high, clears all valid bits; no clearing pass
module int128_alu_top #(
   parameter int WORD_BITS = i128_pkg::WORD_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // op[3:0], a_high[67:4], a_low[131:68], b_high[195:132], b_low[259:196],
   // shift_amount[267:260], zero fill to 272
   input  wire logic [271:0] req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_high[63:0], result_low[127:64], is_equal[128], is_less[129],
   // is_greater[130], divide_by_zero[131], zero fill to 136
   output      logic [135:0] rsp_tdata
);
   localparam int W = WORD_BITS;
   logic stall;
   i128_pkg::ctl_type ctl [W+1];
   logic [W-1:0] rem [W+1];
   logic [W-1:0] num [W+1];
   logic [W-1:0] den [W+1];
   logic [W-1:0] res [W+1];
   logic [127:0] a_raw, b_raw;
   logic         out_valid_ff;
   logic [135:0] out_data_ff;
   logic [W-1:0] fin;
   logic [127:0] fin_ext;
   i128_pkg::ctl_type last;

   // output register stalls the pipe only when full and not taken
   assign stall      = out_valid_ff && !rsp_tready;
   assign req_tready = !stall;
   assign a_raw = {req_tdata[67:4], req_tdata[131:68]};
   assign b_raw = {req_tdata[195:132], req_tdata[259:196]};

   i128_front #(.W(W)) u_front (
      .clock, .reset, .stall,
      .in_valid(req_tvalid), .op(req_tdata[3:0]),
      .a_raw, .b_raw, .shift_amount(req_tdata[267:260]),
      .ctl_o(ctl[0]), .num_o(num[0]), .den_o(den[0]), .res_o(res[0])
   );
   assign rem[0] = '0;

   // divider row
   for (genvar g = 0; g < W; g++) begin : g_cell
      i128_div_cell #(.W(W)) u_cell (
         .clock, .reset, .stall,
         .ctl_i(ctl[g]), .rem_i(rem[g]), .num_i(num[g]), .den_i(den[g]), .res_i(res[g]),
         .ctl_o(ctl[g+1]), .rem_o(rem[g+1]), .num_o(num[g+1]), .den_o(den[g+1]),
         .res_o(res[g+1])
      );
   end

   // result select and sign fix
   always_comb begin
      last = ctl[W];
      fin  = res[W];
      if (!last.dz) begin
         if (last.op == i128_pkg::OP_DIV) begin
            fin = last.neg_q ? (~num[W] + 1'b1) : num[W];
         end else if (last.op == i128_pkg::OP_REM) begin
            fin = last.neg_r ? (~rem[W] + 1'b1) : rem[W];
         end
      end
      fin_ext = 128'($signed(fin));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall) begin
         out_valid_ff <= last.valid;
      end
      if (!stall) begin
         if (last.op == i128_pkg::OP_CMP) begin
            out_data_ff <= {4'd0, 1'b0, res[W][2:0], 128'd0};
         end else begin
            out_data_ff <= {4'd0, last.dz, 3'd0, fin_ext[63:0], fin_ext[127:64]};
         end
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(rsp_tdata)) else $error("rsp beat changed while stalled");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready)) else $error("ready mismatch");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[131] && (rsp_tdata[130:128] != 3'd0)))
      else $error("compare and zero divisor flags together");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_int128_alu_top.sv =====
`default_nettype none
module tb_int128_alu_top;

   localparam int LATENCY   = i128_pkg::WORD_BITS_DEF + 2;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic [7:0]  shamt;
      logic [63:0] b_low;
      logic [63:0] b_high;
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [3:0]  op;
   } alu_req_type;

   typedef struct packed {
      logic        dz;
      logic        gt;
      logic        lt;
      logic        eq;
      logic [63:0] res_low;
      logic [63:0] res_high;
   } alu_rsp_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [271:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   int       errors;
   int       cycle_count;
   int       burst_left;
   int       gap_left;
   bit       stim_done;
   bit       drain_hold;
   bit       req_fire;
   int       hold_at;
   int       sent;

   int128_alu_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // truncating signed divide or remainder on restoring magnitudes
   function automatic logic [127:0] divide_result(logic [127:0] a, logic [127:0] b,
                                                  bit want_rem);
      logic [127:0] na;
      logic [127:0] nb;
      logic [127:0] quo;
      logic [128:0] rem;
      na = a[127] ? -a : a;
      nb = b[127] ? -b : b;
      quo = '0;
      rem = '0;
      for (int i = 127; i >= 0; i--) begin
         rem = {rem[127:0], na[i]};
         if (rem >= {1'b0, nb}) begin
            rem = rem - {1'b0, nb};
            quo[i] = 1'b1;
         end
      end
      if (want_rem) return a[127] ? -rem[127:0] : rem[127:0];
      return (a[127] ^ b[127]) ? -quo : quo;
   endfunction

   function automatic alu_rsp_type alu_compute(alu_req_type r);
      alu_rsp_type o;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic [127:0] res;
      a = {r.a_high, r.a_low};
      b = {r.b_high, r.b_low};
      res = '0;
      o = '0;
      case (r.op)
         i128_pkg::OP_ADD: res = a + b;
         i128_pkg::OP_SUB: res = a - b;
         i128_pkg::OP_MUL: res = a * b;
         i128_pkg::OP_DIV, i128_pkg::OP_REM: begin
            if (b == 0) begin
               o.dz = 1'b1;
               res = (r.op == i128_pkg::OP_DIV) ? '1 : a;
            end else begin
               res = divide_result(a, b, r.op == i128_pkg::OP_REM);
            end
         end
         i128_pkg::OP_SHL: res = (r.shamt >= 128) ? '0 : a << r.shamt;
         i128_pkg::OP_SAR: begin
            if (r.shamt >= 128) res = {128{a[127]}};
            else res = a >>> r.shamt;
         end
         i128_pkg::OP_AND: res = a & b;
         i128_pkg::OP_OR:  res = a | b;
         i128_pkg::OP_CMP: begin
            o.eq = (a == b);
            o.lt = (a < b);
            o.gt = (a > b);
         end
         default: res = '0;
      endcase
      o.res_high = res[127:64];
      o.res_low = res[63:0];
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2: v = 64'h8000_0000_0000_0000;
         3: v = 64'h7fff_ffff_ffff_ffff;
         4: v = 64'($urandom_range(0, 20));
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_req(logic [3:0] op, logic [127:0] a, logic [127:0] b,
                          logic [7:0] sh);
      alu_req_type r;
      r.op = op;
      r.a_high = a[127:64];
      r.a_low = a[63:0];
      r.b_high = b[127:64];
      r.b_low = b[63:0];
      r.shamt = sh;
      pending_reqs.push_back(r);
   endtask

   // clock and stimulus
   initial begin
      logic [127:0] min_v;
      logic [127:0] max_v;
      alu_req_type r;
      clock = 1'b0;
      min_v = {1'b1, 127'b0};
      max_v = {1'b0, {127{1'b1}}};
      add_req(i128_pkg::OP_ADD, max_v, 128'd1, 8'd0);
      add_req(i128_pkg::OP_SUB, min_v, 128'd1, 8'd0);
      add_req(i128_pkg::OP_MUL, '1, '1, 8'd0);
      add_req(i128_pkg::OP_MUL, {64'd0, '1}, {64'd0, '1}, 8'd0);
      add_req(i128_pkg::OP_DIV, min_v, '1, 8'd0);
      add_req(i128_pkg::OP_DIV, -128'sd7, 128'sd2, 8'd0);
      add_req(i128_pkg::OP_REM, -128'sd7, 128'sd2, 8'd0);
      add_req(i128_pkg::OP_REM, 128'sd7, -128'sd2, 8'd0);
      add_req(i128_pkg::OP_DIV, 128'sd5, 128'd0, 8'd0);
      add_req(i128_pkg::OP_REM, -128'sd5, 128'd0, 8'd0);
      add_req(i128_pkg::OP_SHL, '1, '0, 8'd127);
      add_req(i128_pkg::OP_SHL, '1, '0, 8'd128);
      add_req(i128_pkg::OP_SHL, 128'd1, '0, 8'd64);
      add_req(i128_pkg::OP_SAR, min_v, '0, 8'd255);
      add_req(i128_pkg::OP_SAR, max_v, '0, 8'd200);
      add_req(i128_pkg::OP_SAR, min_v, '0, 8'd0);
      add_req(i128_pkg::OP_SAR, min_v, '0, 8'd64);
      add_req(i128_pkg::OP_AND, '1, max_v, 8'd0);
      add_req(i128_pkg::OP_OR, min_v, 128'd5, 8'd0);
      add_req(i128_pkg::OP_CMP, min_v, max_v, 8'd0);
      add_req(i128_pkg::OP_CMP, max_v, min_v, 8'd0);
      add_req(i128_pkg::OP_CMP, 128'd3, 128'd3, 8'd0);
      add_req(4'd10, '1, '1, 8'd3);
      add_req(4'd15, '1, '1, 8'd3);
      for (int i = 0; i < 1400; i++) begin
         r.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
         r.a_high = rand64();
         r.a_low = rand64();
         r.b_high = rand64();
         r.b_low = rand64();
         if ($urandom_range(0, 3) == 0) begin
            r.b_high = {64{r.b_low[63]}};
            r.b_low = $urandom_range(0, 3) == 0 ? 64'd0 : {32'd0, $urandom()};
         end
         if ($urandom_range(0, 5) == 0) {r.b_high, r.b_low} = {r.a_high, r.a_low};
         r.shamt = 8'($urandom_range(0, 255));
         pending_reqs.push_back(r);
      end
      hold_at = pending_reqs.size() / 2;
      forever #2 clock = ~clock;
   end

   // req beat taken at this rising edge
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
   end

   // driver: bursts and gaps, one pause to drain midway
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_fire) begin
         if (req_tvalid) begin
            expected_rsps.push_back(alu_compute(alu_req_type'(req_tdata[267:0])));
            sent++;
         end
         if (sent == hold_at && !drain_hold) drain_hold = 1'b1;
         if (drain_hold && expected_rsps.size() == 0 && !req_tvalid) drain_hold = 1'b0;
         if (gap_left > 0) gap_left--;
         if (pending_reqs.size() == 0) begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end else if (gap_left > 0 || (drain_hold && sent == hold_at)) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= {4'd0, pending_reqs.pop_front()};
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (cycle_count[9]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // monitor: compare each rsp beat with the oldest expectation
   always @(posedge clock) begin
      alu_rsp_type got;
      alu_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alu_rsp_type'(rsp_tdata[131:0]);
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected rsp beat %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.res_high !== want.res_high)
               $display("%0t: result_high exp %h got %h", $time, want.res_high, got.res_high);
            if (got.res_low !== want.res_low)
               $display("%0t: result_low exp %h got %h", $time, want.res_low, got.res_low);
            if (got.eq !== want.eq)
               $display("%0t: is_equal exp %b got %b", $time, want.eq, got.eq);
            if (got.lt !== want.lt)
               $display("%0t: is_less exp %b got %b", $time, want.lt, got.lt);
            if (got.gt !== want.gt)
               $display("%0t: is_greater exp %b got %b", $time, want.gt, got.gt);
            if (got.dz !== want.dz)
               $display("%0t: divide_by_zero exp %b got %b", $time, want.dz, got.dz);
            if (got !== want) errors++;
         end
      end
   end

   // reset, end of run and timeout
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      errors = 0;
      cycle_count = 0;
      burst_left = 0;
      gap_left = 0;
      stim_done = 1'b0;
      drain_hold = 1'b0;
      req_fire = 1'b0;
      sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && !req_tvalid && expected_rsps.size() == 0);
            repeat (LATENCY * 2) @(posedge clock);
         end
         begin
            while (cycle_count < CYCLE_MAX) begin
               @(posedge clock);
               cycle_count++;
            end
            errors++;
         end
      join_any
      if (errors == 0 && expected_rsps.size() == 0) $display("tb_int128_alu_top: PASS");
      else $display("tb_int128_alu_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
